// ----- src/lfs_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and CRC step for the log frame scanner.
package lfs_pkg;

   localparam int unsigned OUT_BITS       = 40;
   localparam int unsigned CSR_INDEX_BITS = 2;
   localparam int unsigned CSR_DATA_BITS  = 32;
   localparam int unsigned QUEUE_DEPTH    = 4;
   localparam int unsigned LOG_START      = 8;

   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

   localparam logic [31:0] MAX_PAYLOAD_RESET   = 32'(64 * 1024 * 1024);
   localparam logic [7:0]  BEGIN_OPCODE_RESET  = 8'd1;
   localparam logic [7:0]  COMMIT_OPCODE_RESET = 8'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_PAYLOAD   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BEGIN_OPCODE  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COMMIT_OPCODE = 2'd2;

   localparam logic KIND_REPORT  = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef struct packed {
      logic                has_report;
      logic                has_summary;
      logic [7:0]          frame_op;
      logic [31:0]         frame_length;
      logic [63:0]         frame_time;
      logic [OUT_BITS-1:0] frame_offset;
      logic [OUT_BITS-1:0] clean_end;
      logic [OUT_BITS-1:0] stop_offset;
      logic [OUT_BITS-1:0] open_start;
      logic                has_pending;
      logic                damaged;
   } lfs_event_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ----- src/lfs_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts log bytes, parses frames, checks CRC and queues events.
module lfs_front #(
   parameter int unsigned OFFSET_BITS = 40
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_log_byte,
   input  logic                                 req_byte_present,
   input  logic                                 req_end_of_log,
   input  logic                                 csr_write,
   input  logic [lfs_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [lfs_pkg::CSR_DATA_BITS-1:0]    csr_data,
   input  logic                                 queue_full,
   output logic                                 push,
   output lfs_pkg::lfs_event_type               push_data
);

   typedef enum logic [2:0] {
      PH_LEN,
      PH_OP,
      PH_TIME,
      PH_PAY,
      PH_CRC
   } phase_type;

   localparam logic [OFFSET_BITS-1:0] START = OFFSET_BITS'(lfs_pkg::LOG_START);

   phase_type              phase_ff, phase_in;
   logic [31:0]            count_ff, count_in;
   logic [31:0]            length_ff, length_in;
   logic [7:0]             op_ff, op_in;
   logic [63:0]            time_ff, time_in;
   logic [31:0]            crc_ff, crc_in;
   logic [31:0]            stored_ff, stored_in;
   logic [OFFSET_BITS-1:0] position_ff, position_in;
   logic [OFFSET_BITS-1:0] frame_start_ff, frame_start_in;
   logic [OFFSET_BITS-1:0] good_end_ff, good_end_in;
   logic [OFFSET_BITS-1:0] open_begin_ff, open_begin_in;
   logic                   open_valid_ff, open_valid_in;
   logic                   halted_ff, halted_in;
   logic                   damage_ff, damage_in;
   logic [31:0]            max_payload_ff, max_payload_in;
   logic [7:0]             begin_op_ff, begin_op_in;
   logic [7:0]             commit_op_ff, commit_op_in;

   logic                   accept;
   logic                   good;
   logic [31:0]            crc_start;
   logic [31:0]            pay_next;
   lfs_pkg::lfs_event_type evt;

   function automatic logic [lfs_pkg::OUT_BITS-1:0] to_out(input logic [OFFSET_BITS-1:0] v);
      logic [63:0] w;
      w = 64'(v);
      return w[lfs_pkg::OUT_BITS-1:0];
   endfunction

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;
   assign crc_start = (phase_ff == PH_LEN && count_ff == 32'd0) ? lfs_pkg::CRC_ONES : crc_ff;
   assign pay_next  = count_ff + 32'd1;

   always_comb begin
      max_payload_in = max_payload_ff;
      begin_op_in    = begin_op_ff;
      commit_op_in   = commit_op_ff;
      if (csr_write) begin
         case (csr_index)
            lfs_pkg::CSR_MAX_PAYLOAD:   max_payload_in = csr_data;
            lfs_pkg::CSR_BEGIN_OPCODE:  begin_op_in    = csr_data[7:0];
            lfs_pkg::CSR_COMMIT_OPCODE: commit_op_in   = csr_data[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in       = phase_ff;
      count_in       = count_ff;
      length_in      = length_ff;
      op_in          = op_ff;
      time_in        = time_ff;
      crc_in         = crc_ff;
      stored_in      = stored_ff;
      position_in    = position_ff;
      frame_start_in = frame_start_ff;
      good_end_in    = good_end_ff;
      open_begin_in  = open_begin_ff;
      open_valid_in  = open_valid_ff;
      halted_in      = halted_ff;
      damage_in      = damage_ff;
      good           = 1'b0;
      evt            = '0;

      if (accept && req_byte_present && !halted_ff) begin
         position_in = position_ff + OFFSET_BITS'(1);
         if (phase_ff != PH_CRC) begin
            crc_in = lfs_pkg::crc_byte(crc_start, req_log_byte);
         end
         case (phase_ff)
            PH_LEN: begin
               if (count_ff == 32'd0) begin
                  frame_start_in = position_ff;
                  length_in      = {24'd0, req_log_byte};
               end else begin
                  length_in = length_ff | ({24'd0, req_log_byte} << {count_ff[1:0], 3'b000});
               end
               count_in = pay_next;
               if (count_ff == 32'd3) begin
                  phase_in = PH_OP;
                  count_in = 32'd0;
               end
            end
            PH_OP: begin
               op_in = req_log_byte;
               if (req_log_byte != begin_op_ff && length_ff > max_payload_ff) begin
                  halted_in = 1'b1;
                  damage_in = 1'b1;
               end else begin
                  phase_in = PH_TIME;
                  count_in = 32'd0;
                  time_in  = 64'd0;
               end
            end
            PH_TIME: begin
               time_in  = time_ff | ({56'd0, req_log_byte} << {count_ff[2:0], 3'b000});
               count_in = pay_next;
               if (count_ff == 32'd7) begin
                  phase_in  = (length_ff != 32'd0) ? PH_PAY : PH_CRC;
                  count_in  = 32'd0;
                  stored_in = 32'd0;
               end
            end
            PH_PAY: begin
               count_in = pay_next;
               if (pay_next == length_ff) begin
                  phase_in  = PH_CRC;
                  count_in  = 32'd0;
                  stored_in = 32'd0;
               end
            end
            PH_CRC: begin
               stored_in = stored_ff | ({24'd0, req_log_byte} << {count_ff[1:0], 3'b000});
               count_in  = pay_next;
               if (count_ff == 32'd3) begin
                  if ((crc_ff ^ lfs_pkg::CRC_ONES) == stored_in) begin
                     if (op_ff == begin_op_ff) begin
                        open_begin_in = frame_start_ff;
                        open_valid_in = 1'b1;
                     end else if (op_ff == commit_op_ff) begin
                        open_valid_in = 1'b0;
                     end
                     good_end_in = position_ff + OFFSET_BITS'(1);
                     good        = 1'b1;
                     phase_in    = PH_LEN;
                     count_in    = 32'd0;
                  end else begin
                     halted_in = 1'b1;
                     damage_in = 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end

      if (good) begin
         evt.has_report   = 1'b1;
         evt.frame_op     = op_ff;
         evt.frame_length = length_ff;
         evt.frame_time   = time_ff;
         evt.frame_offset = to_out(frame_start_ff);
      end

      if (accept && req_end_of_log) begin
         evt.has_summary = 1'b1;
         evt.damaged     = damage_in ||
                           (!halted_in && !(phase_in == PH_LEN && count_in == 32'd0));
         evt.clean_end   = to_out(good_end_in);
         evt.stop_offset = open_valid_in ? to_out(open_begin_in) : to_out(good_end_in);
         evt.open_start  = open_valid_in ? to_out(open_begin_in) : '0;
         evt.has_pending = open_valid_in;

         phase_in       = PH_LEN;
         count_in       = 32'd0;
         length_in      = 32'd0;
         op_in          = 8'd0;
         time_in        = 64'd0;
         crc_in         = lfs_pkg::CRC_ONES;
         stored_in      = 32'd0;
         position_in    = START;
         frame_start_in = START;
         good_end_in    = START;
         open_begin_in  = '0;
         open_valid_in  = 1'b0;
         halted_in      = 1'b0;
         damage_in      = 1'b0;
      end
   end

   assign push      = accept && (good || req_end_of_log);
   assign push_data = evt;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_LEN;
         count_ff       <= 32'd0;
         length_ff      <= 32'd0;
         op_ff          <= 8'd0;
         time_ff        <= 64'd0;
         crc_ff         <= lfs_pkg::CRC_ONES;
         stored_ff      <= 32'd0;
         position_ff    <= START;
         frame_start_ff <= START;
         good_end_ff    <= START;
         open_begin_ff  <= '0;
         open_valid_ff  <= 1'b0;
         halted_ff      <= 1'b0;
         damage_ff      <= 1'b0;
         max_payload_ff <= lfs_pkg::MAX_PAYLOAD_RESET;
         begin_op_ff    <= lfs_pkg::BEGIN_OPCODE_RESET;
         commit_op_ff   <= lfs_pkg::COMMIT_OPCODE_RESET;
      end else begin
         phase_ff       <= phase_in;
         count_ff       <= count_in;
         length_ff      <= length_in;
         op_ff          <= op_in;
         time_ff        <= time_in;
         crc_ff         <= crc_in;
         stored_ff      <= stored_in;
         position_ff    <= position_in;
         frame_start_ff <= frame_start_in;
         good_end_ff    <= good_end_in;
         open_begin_ff  <= open_begin_in;
         open_valid_ff  <= open_valid_in;
         halted_ff      <= halted_in;
         damage_ff      <= damage_in;
         max_payload_ff <= max_payload_in;
         begin_op_ff    <= begin_op_in;
         commit_op_ff   <= commit_op_in;
      end
   end

endmodule

// ----- src/lfs_queue.sv -----
`timescale 1ns / 1ps
// Short event queue between the parser front end and the result back end.
module lfs_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  lfs_pkg::lfs_event_type push_data,
   input  logic                   pop,
   output lfs_pkg::lfs_event_type head,
   output logic                   not_empty,
   output logic                   full
);

   localparam int unsigned DEPTH      = lfs_pkg::QUEUE_DEPTH;
   localparam int unsigned PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned COUNT_BITS = $clog2(DEPTH + 1);

   lfs_pkg::lfs_event_type slot_ff [DEPTH];
   logic [PTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;

   function automatic logic [PTR_BITS-1:0] bump(input logic [PTR_BITS-1:0] p);
      return (p == PTR_BITS'(DEPTH - 1)) ? '0 : p + PTR_BITS'(1);
   endfunction

   assign head      = slot_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == COUNT_BITS'(DEPTH));

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("event queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) pop |-> not_empty)
      else $error("event queue underflow");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(DEPTH))
      else $error("event queue count out of range");
   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (rd_ptr_ff == wr_ptr_ff))
      else $error("event queue pointers disagree with count");

endmodule

// ----- src/lfs_back.sv -----
`timescale 1ns / 1ps
// Back end: expands queued events into result requests on the output register.
module lfs_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_not_empty,
   input  lfs_pkg::lfs_event_type              q_head,
   output logic                                pop,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_kind,
   output logic [7:0]                          rsp_frame_op,
   output logic [31:0]                         rsp_frame_length,
   output logic signed [63:0]                  rsp_frame_time,
   output logic [lfs_pkg::OUT_BITS-1:0]        rsp_frame_offset,
   output logic [lfs_pkg::OUT_BITS-1:0]        rsp_clean_end,
   output logic [lfs_pkg::OUT_BITS-1:0]        rsp_stop_offset,
   output logic [lfs_pkg::OUT_BITS-1:0]        rsp_open_start,
   output logic                                rsp_has_pending,
   output logic                                rsp_damaged,
   output logic                                rsp_last_result
);

   logic                         valid_ff, valid_in;
   logic                         sent_ff, sent_in;
   logic                         kind_ff, kind_in;
   logic [7:0]                   op_ff, op_in;
   logic [31:0]                  length_ff, length_in;
   logic [63:0]                  time_ff, time_in;
   logic [lfs_pkg::OUT_BITS-1:0] offset_ff, offset_in;
   logic [lfs_pkg::OUT_BITS-1:0] clean_end_ff, clean_end_in;
   logic [lfs_pkg::OUT_BITS-1:0] stop_ff, stop_in;
   logic [lfs_pkg::OUT_BITS-1:0] pending_ff, pending_in;
   logic                         has_pending_ff, has_pending_in;
   logic                         damaged_ff, damaged_in;
   logic                         last_ff, last_in;
   logic                         load;

   assign load = q_not_empty && (!valid_ff || !rsp_stall);

   always_comb begin
      valid_in       = valid_ff;
      sent_in        = sent_ff;
      kind_in        = kind_ff;
      op_in          = op_ff;
      length_in      = length_ff;
      time_in        = time_ff;
      offset_in      = offset_ff;
      clean_end_in   = clean_end_ff;
      stop_in        = stop_ff;
      pending_in     = pending_ff;
      has_pending_in = has_pending_ff;
      damaged_in     = damaged_ff;
      last_in        = last_ff;
      pop            = 1'b0;

      if (load) begin
         valid_in = 1'b1;
         if (q_head.has_report && !sent_ff) begin
            kind_in        = lfs_pkg::KIND_REPORT;
            op_in          = q_head.frame_op;
            length_in      = q_head.frame_length;
            time_in        = q_head.frame_time;
            offset_in      = q_head.frame_offset;
            clean_end_in   = '0;
            stop_in        = '0;
            pending_in     = '0;
            has_pending_in = 1'b0;
            damaged_in     = 1'b0;
            last_in        = !q_head.has_summary;
            sent_in        = q_head.has_summary;
            pop            = !q_head.has_summary;
         end else begin
            kind_in        = lfs_pkg::KIND_SUMMARY;
            op_in          = 8'd0;
            length_in      = 32'd0;
            time_in        = 64'd0;
            offset_in      = '0;
            clean_end_in   = q_head.clean_end;
            stop_in        = q_head.stop_offset;
            pending_in     = q_head.open_start;
            has_pending_in = q_head.has_pending;
            damaged_in     = q_head.damaged;
            last_in        = 1'b1;
            sent_in        = 1'b0;
            pop            = 1'b1;
         end
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sent_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sent_ff  <= sent_in;
      end
      kind_ff        <= kind_in;
      op_ff          <= op_in;
      length_ff      <= length_in;
      time_ff        <= time_in;
      offset_ff      <= offset_in;
      clean_end_ff   <= clean_end_in;
      stop_ff        <= stop_in;
      pending_ff     <= pending_in;
      has_pending_ff <= has_pending_in;
      damaged_ff     <= damaged_in;
      last_ff        <= last_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_frame_op      = op_ff;
   assign rsp_frame_length  = length_ff;
   assign rsp_frame_time    = $signed(time_ff);
   assign rsp_frame_offset  = offset_ff;
   assign rsp_clean_end     = clean_end_ff;
   assign rsp_stop_offset   = stop_ff;
   assign rsp_open_start    = pending_ff;
   assign rsp_has_pending   = has_pending_ff;
   assign rsp_damaged       = damaged_ff;
   assign rsp_last_result   = last_ff;

endmodule

// ----- src/log_frame_scanner.sv -----
`timescale 1ns / 1ps
// Top level of the CRC-32 framed log scanner.
// The scanner takes one log byte per cycle, with no stall of its own while the
// event queue has room: parsing, the one-byte CRC update and the length, op and
// timestamp field counters all run combinationally in the front end. Each item
// that completes a good frame or ends the log places one event in a four-entry
// queue; the back end drains it through an output register at one result per
// cycle while the result side does not stall, and an item that yields both a
// frame report and the end-of-log summary gives the report first, then the summary.
// A request's event is held in a queue slot register and then in the output register.
module log_frame_scanner #(
   parameter int unsigned OFFSET_BITS = 40
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_log_byte,
   input  logic                                req_byte_present,
   input  logic                                req_end_of_log,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_kind,
   output logic [7:0]                          rsp_frame_op,
   output logic [31:0]                         rsp_frame_length,
   output logic signed [63:0]                  rsp_frame_time,
   output logic [lfs_pkg::OUT_BITS-1:0]        rsp_frame_offset,
   output logic [lfs_pkg::OUT_BITS-1:0]        rsp_clean_end,
   output logic [lfs_pkg::OUT_BITS-1:0]        rsp_stop_offset,
   output logic [lfs_pkg::OUT_BITS-1:0]        rsp_open_start,
   output logic                                rsp_has_pending,
   output logic                                rsp_damaged,
   output logic                                rsp_last_result,
   input  logic                                csr_write,
   input  logic [lfs_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [lfs_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   logic                   push;
   logic                   pop;
   logic                   queue_full;
   logic                   queue_not_empty;
   lfs_pkg::lfs_event_type push_data;
   lfs_pkg::lfs_event_type queue_head;

   lfs_front #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_log_byte     (req_log_byte),
      .req_byte_present (req_byte_present),
      .req_end_of_log   (req_end_of_log),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .queue_full       (queue_full),
      .push             (push),
      .push_data        (push_data)
   );

   lfs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (queue_head),
      .not_empty (queue_not_empty),
      .full      (queue_full)
   );

   lfs_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_not_empty       (queue_not_empty),
      .q_head            (queue_head),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_frame_op      (rsp_frame_op),
      .rsp_frame_length  (rsp_frame_length),
      .rsp_frame_time    (rsp_frame_time),
      .rsp_frame_offset  (rsp_frame_offset),
      .rsp_clean_end     (rsp_clean_end),
      .rsp_stop_offset   (rsp_stop_offset),
      .rsp_open_start    (rsp_open_start),
      .rsp_has_pending   (rsp_has_pending),
      .rsp_damaged       (rsp_damaged),
      .rsp_last_result   (rsp_last_result)
   );

endmodule
